// ----- rtl/cfpc_pkg.sv -----
// Package for the CRC framed packet checker.
// Holds the frame constants, the status codes and the result record type.
// No dependencies.
`default_nettype none

package cfpc_pkg;

  localparam int unsigned POS_W = 9;
  localparam int unsigned TOTAL_W = POS_W + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [TOTAL_W-1:0] MIN_FRAME = TOTAL_W'(5);
  localparam logic [TOTAL_W-1:0] CHECK_BYTES = TOTAL_W'(2);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_LEN_MISMATCH = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic kind;
    logic [7:0] pbyte;
    logic [7:0] pindex;
    status_t status;
    logic [7:0] mtype;
    logic [7:0] seq;
    logic [7:0] plen;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/cfpc_crc_byte.sv -----
// CRC-16 (polynomial 0x1021, MSB first) update by one whole byte.
// Purely combinational, eight bit steps unrolled. Depends on cfpc_pkg.
`default_nettype none

module cfpc_crc_byte
  import cfpc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic [15:0]      crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- rtl/cfpc_skid.sv -----
// Output register with one skid entry for the checker's result records.
// Depends on cfpc_pkg for the result record type.
`default_nettype none

module cfpc_skid
  import cfpc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic skid_valid;
  result_t skid_data;
  logic take;
  logic load_out;

  assign take = out_valid & ~out_stall;
  // The output slot is free when empty or being emptied this cycle.
  assign load_out = push & (~out_valid | take);
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end else if (take && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/crc_framed_packet_checker.sv -----
// Each result is registered in the output stage (output register or skid entry) when its byte is taken.
// Throughput: one byte per cycle while in_stall is low; in_stall is raised while the skid entry is occupied.
// A skid entry lets a byte be taken while a finished result is still stalled.
// Reset (rst, synchronous) clears the frame state and empties the output stage.
// Depends on cfpc_pkg, cfpc_crc_byte and cfpc_skid.
`default_nettype none

module crc_framed_packet_checker
  import cfpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_frame,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            result_kind,
  output logic [7:0]      payload_byte,
  output logic [7:0]      payload_index,
  output logic [1:0]      frame_status,
  output logic [7:0]      message_type,
  output logic [7:0]      sequence_number,
  output logic [7:0]      payload_length
);

  // Frame state. The byte position counts the bytes received in the current
  // frame and saturates at its maximum, so an overlong frame always ends with
  // a length mismatch.
  logic [POS_W-1:0] byte_position;
  logic [15:0] crc_accumulator;
  logic [7:0] declared_length;
  logic [7:0] type_holding;
  logic [7:0] sequence_holding;
  logic [15:0] received_check;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0] crc_accumulator_next;
  logic [7:0] declared_length_next;
  logic [7:0] type_holding_next;
  logic [7:0] sequence_holding_next;
  logic [15:0] received_check_next;

  logic in_accept;
  logic [15:0] crc_fed;
  logic [POS_W-1:0] covered;
  logic in_crc;
  logic is_payload;
  logic [TOTAL_W-1:0] total;
  status_t status;
  result_t result;
  logic push;
  logic skid_full;
  result_t out_data;

  assign in_stall = skid_full;
  assign in_accept = in_valid & ~in_stall;

  cfpc_crc_byte u_crc (
    .crc_in  (crc_accumulator),
    .data    (data_byte),
    .crc_out (crc_fed)
  );

  always_comb begin
    // The header bytes are captured at their positions; the status at the end
    // of a frame sees the values including the byte that arrives now.
    type_holding_next = (byte_position == POS_W'(0)) ? data_byte : type_holding;
    sequence_holding_next = (byte_position == POS_W'(1)) ? data_byte : sequence_holding;
    declared_length_next = (byte_position == POS_W'(2)) ? data_byte : declared_length;

    // Header and declared payload are covered by the CRC; anything beyond goes
    // into the received check word, which keeps the last two such bytes.
    covered = HEADER_BYTES + {1'b0, declared_length_next};
    in_crc = (byte_position < HEADER_BYTES) || (byte_position < covered);
    is_payload = in_crc && (byte_position >= HEADER_BYTES);

    crc_accumulator_next = in_crc ? crc_fed : crc_accumulator;
    received_check_next = in_crc ? received_check : {received_check[7:0], data_byte};

    total = {1'b0, byte_position} + TOTAL_W'(1);
    priority if (total < MIN_FRAME) begin
      status = ST_TOO_SHORT;
    end else if (total != ({1'b0, covered} + CHECK_BYTES)) begin
      status = ST_LEN_MISMATCH;
    end else if (received_check_next != crc_accumulator_next) begin
      status = ST_CRC_MISMATCH;
    end else begin
      status = ST_OK;
    end

    // Fields that do not belong to the record's kind read as zero.
    result = '0;
    if (end_of_frame) begin
      result.kind = KIND_STATUS;
      result.status = status;
      result.mtype = type_holding_next;
      result.seq = sequence_holding_next;
      result.plen = declared_length_next;
    end else begin
      result.kind = KIND_PAYLOAD;
      result.pbyte = data_byte;
      result.pindex = 8'(byte_position - HEADER_BYTES);
    end

    // A payload byte that ends the frame produces only the status record.
    push = in_accept & (end_of_frame | is_payload);

    byte_position_next = (byte_position < POS_MAX) ? byte_position + POS_W'(1)
                                                   : byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_accumulator <= CRC_INIT;
      declared_length <= '0;
      type_holding <= '0;
      sequence_holding <= '0;
      received_check <= '0;
    end else if (in_accept) begin
      if (end_of_frame) begin
        // The frame is complete: back to the reset state for the next one.
        byte_position <= '0;
        crc_accumulator <= CRC_INIT;
        declared_length <= '0;
        type_holding <= '0;
        sequence_holding <= '0;
        received_check <= '0;
      end else begin
        byte_position <= byte_position_next;
        crc_accumulator <= crc_accumulator_next;
        declared_length <= declared_length_next;
        type_holding <= type_holding_next;
        sequence_holding <= sequence_holding_next;
        received_check <= received_check_next;
      end
    end
  end

  cfpc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign result_kind = out_data.kind;
  assign payload_byte = out_data.pbyte;
  assign payload_index = out_data.pindex;
  assign frame_status = out_data.status;
  assign message_type = out_data.mtype;
  assign sequence_number = out_data.seq;
  assign payload_length = out_data.plen;

  // A byte taken while the skid entry is occupied would lose a result.
  assert property (@(posedge clk) disable iff (rst) skid_full |-> out_valid)
    else $error("skid entry occupied while output register is empty");

  // Completing a frame must restart the position count and the CRC.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_of_frame) |=> (byte_position == '0 && crc_accumulator == CRC_INIT))
    else $error("frame state not restarted after end of frame");

  // Within a frame the position never falls back to the first byte.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && !end_of_frame) |=> (byte_position != '0))
    else $error("byte position wrapped inside a frame");

  // When the output register can take it directly, a status record follows the last byte of a frame.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_of_frame && !skid_full && (!out_valid || !out_stall))
      |=> (out_valid && result_kind == KIND_STATUS))
    else $error("no status record after end of frame");

endmodule

`default_nettype wire
